@@ hw/rtl/ic_pkg.sv @@
// Shared types and constants for the inversion counter.
package ic_pkg;

  localparam int IC_MAX_ITEMS = 1024;
  localparam int IC_VALUE_W   = 32;
  localparam int IC_TOTAL_W   = 19;
  localparam logic [IC_TOTAL_W-1:0] IC_TOTAL_MAX = '1;

  // Word travelling down the cell row; the partial count rides alongside it.
  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic                         placed;
    logic signed [IC_VALUE_W-1:0] value;
  } ic_tok_t;

endpackage

@@ hw/rtl/ic_cell.sv @@
// One compare cell: holds a stored value and counts passing words it exceeds.
module ic_cell import ic_pkg::*; #(
  parameter int CNT_W = $clog2(IC_MAX_ITEMS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ic_tok_t          tok_in,
  input  logic [CNT_W-1:0] cnt_in,
  output ic_tok_t          tok_out,
  output logic [CNT_W-1:0] cnt_out
);

  ic_tok_t                      tok_r, tok_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         occ_r, occ_nxt;
  logic signed [IC_VALUE_W-1:0] val_r, val_nxt;

  always_comb begin
    tok_nxt = tok_in;
    cnt_nxt = cnt_in;
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (tok_in.valid) begin
      if (occ_r) begin
        if (val_r > tok_in.value) begin
          cnt_nxt = cnt_in + CNT_W'(1);
        end
        // final word of a sequence empties the row behind it
        if (tok_in.last) begin
          occ_nxt = 1'b0;
        end
      end else if (!tok_in.placed) begin
        tok_nxt.placed = 1'b1;
        if (!tok_in.last) begin
          occ_nxt = 1'b1;
          val_nxt = tok_in.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      occ_r       <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    val_r <= val_nxt;
  end

  assign tok_out = tok_r;
  assign cnt_out = cnt_r;

endmodule

@@ hw/rtl/ic_tail.sv @@
// End of the cell row: saturating total, drop flag and output register.
module ic_tail import ic_pkg::*; #(
  parameter int CNT_W = $clog2(IC_MAX_ITEMS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ic_tok_t               tok_in,
  input  logic [CNT_W-1:0]      cnt_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IC_TOTAL_W-1:0] out_inversions,
  output logic                  out_overflow
);

  localparam int SUM_W = IC_TOTAL_W + 1;

  logic [IC_TOTAL_W-1:0] total_r, total_nxt;
  logic                  drop_r, drop_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [IC_TOTAL_W-1:0] oinv_r, oinv_nxt;
  logic                  oovf_r, oovf_nxt;
  logic [SUM_W-1:0]      sum;
  logic [IC_TOTAL_W-1:0] sat_sum;
  logic [IC_TOTAL_W-1:0] add_total;

  always_comb begin
    sum = {1'b0, total_r} + {{(SUM_W-CNT_W){1'b0}}, cnt_in};
    if (sum > {1'b0, IC_TOTAL_MAX}) begin
      sat_sum = IC_TOTAL_MAX;
    end else begin
      sat_sum = sum[IC_TOTAL_W-1:0];
    end
    // a word that found no free cell was dropped and adds nothing
    add_total = tok_in.placed ? sat_sum : total_r;
  end

  always_comb begin
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    ovalid_nxt = ovalid_r;
    oinv_nxt   = oinv_r;
    oovf_nxt   = oovf_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (tok_in.valid) begin
      if (tok_in.last) begin
        ovalid_nxt = 1'b1;
        oinv_nxt   = add_total;
        oovf_nxt   = drop_r | ~tok_in.placed;
        total_nxt  = '0;
        drop_nxt   = 1'b0;
      end else begin
        total_nxt = add_total;
        drop_nxt  = drop_r | ~tok_in.placed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oinv_r <= oinv_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_inversions = oinv_r;
  assign out_overflow   = oovf_r;

endmodule

@@ hw/rtl/inversion_counter.sv @@
// Inversion counter top level: input stage, row of compare cells and tail.
// Each value enters a row of MAX_ITEMS compare cells and moves one cell per
// cycle; the n-th value of a sequence settles in cell n, and every later
// value counts the stored values strictly greater than itself as it passes.
// Within a sequence one word is taken every cycle. The final word is loaded
// into the first cell at the edge that accepts it, passes registered through
// the rest of the row, and the result appears from the tail register. From
// that final word until the result is taken the input is stalled. The final
// word also empties the cells as it passes, so a new sequence needs no
// clearing pass. Values past MAX_ITEMS in a sequence are dropped and reported
// through out_overflow; the total saturates at its 19-bit maximum.
module inversion_counter import ic_pkg::*; #(
  parameter int MAX_ITEMS = IC_MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [IC_VALUE_W-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [IC_TOTAL_W-1:0]        out_inversions,
  output logic                         out_overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  ic_tok_t          tok   [MAX_ITEMS+1];
  logic [CNT_W-1:0] cnt   [MAX_ITEMS+1];
  logic             busy_r, busy_nxt;
  logic             in_acc;

  assign in_acc = in_valid && !busy_r;

  // held from a final word until its result is taken
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc && in_last) begin
      busy_nxt = 1'b1;
    end else if (out_valid && !out_stall) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign in_stall = busy_r;

  assign tok[0] = '{valid: in_acc, last: in_last, placed: 1'b0, value: in_value};
  assign cnt[0] = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    ic_cell #(.CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .cnt_in  (cnt[g]),
      .tok_out (tok[g+1]),
      .cnt_out (cnt[g+1])
    );
  end

  ic_tail #(.CNT_W(CNT_W)) u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_in         (tok[MAX_ITEMS]),
    .cnt_in         (cnt[MAX_ITEMS]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inversions (out_inversions),
    .out_overflow   (out_overflow)
  );

endmodule

@@ hw/rtl/ic_checker.sv @@
// Port-level checks for the inversion counter, bound to the top level.
module ic_checker import ic_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [IC_TOTAL_W-1:0]        out_inversions,
  input logic                         out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inversions)
      && $stable(out_overflow))
    else $error("stalled result word changed");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not stalled after final word");

  a_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid && !in_stall)
    else $error("input not released after result taken");

endmodule

bind inversion_counter ic_checker u_ic_checker (.*);
